// ===== rtl/ecu_pkg.sv =====
package ecu_pkg;

  localparam int SECS_PER_DAY = 86400;
  localparam int EPOCH_SHIFT  = 719468;
  localparam int DAYS_PER_ERA = 146097;

  // quotient bits resolved per divider chunk
  localparam int DIV_STEPS = 8;

  localparam int SEC_W  = 64;
  localparam int DAY_W  = 48;
  localparam int ERA_W  = 32;
  localparam int TOD_W  = 17;
  localparam int DOE_W  = 18;
  localparam int YEAR_W = 40;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

endpackage

// ===== rtl/ecu_cdiv.sv =====
module ecu_cdiv #(
  parameter int W       = 64,
  parameter int DIVISOR = 86400,
  parameter int SPS     = 8,
  parameter int SIDE_W  = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [W-1:0]                    dividend,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            out_valid,
  output logic [W-1:0]                    quotient,
  output logic [$clog2(DIVISOR+1)-1:0]    remainder,
  output logic [SIDE_W-1:0]               side_out
);

  localparam int RW  = $clog2(DIVISOR + 1);
  localparam int NST = (W + SPS - 1) / SPS;
  localparam int WP  = NST * SPS;
  // partial dividend of one chunk: remainder so far with the next SPS bits
  localparam int TW  = RW + SPS;
  // rounded-up reciprocal, exact for every partial dividend below 2^TW
  localparam int SH  = TW + $clog2(DIVISOR);
  localparam logic [TW:0] MAGIC =
    (TW + 1)'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [WP-1:0]     acc_o  [NST];
  logic [RW-1:0]     rem_o  [NST];
  logic [SIDE_W-1:0] side_o [NST];
  logic              vld_o  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [WP-1:0]     acc_in;
    logic [RW-1:0]     r_in;
    logic [SIDE_W-1:0] sd_in;
    logic              v_in;
    logic [TW-1:0]     t_in;
    logic [2*TW:0]     prod;
    logic [SPS-1:0]    q_dig;
    logic [TW-1:0]     r_full;
    // digit registers, filled first
    logic [TW-1:0]     t_a;
    logic [WP-1:0]     acc_a;
    logic [SIDE_W-1:0] sd_a;
    logic              v_a;
    // remainder registers, fed from the digit registers
    logic [RW-1:0]     r_b;
    logic [WP-1:0]     acc_b;
    logic [SIDE_W-1:0] sd_b;
    logic              v_b;

    if (s == 0) begin : g_first
      assign acc_in = WP'(dividend);
      assign r_in   = '0;
      assign sd_in  = side_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign acc_in = acc_o[s-1];
      assign r_in   = rem_o[s-1];
      assign sd_in  = side_o[s-1];
      assign v_in   = vld_o[s-1];
    end

    // quotient digit by reciprocal multiplication
    assign t_in  = {r_in, acc_in[WP-1 -: SPS]};
    assign prod  = {{(TW + 1){1'b0}}, t_in} * {{TW{1'b0}}, MAGIC};
    assign q_dig = prod[SH +: SPS];

    // remainder left after the digit
    assign r_full = t_a - {{RW{1'b0}}, acc_a[SPS-1:0]} * TW'(DIVISOR);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a <= 1'b0;
        v_b <= 1'b0;
      end else if (en) begin
        v_a <= v_in;
        v_b <= v_a;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_a   <= t_in;
        acc_a <= {acc_in[WP-SPS-1:0], q_dig};
        sd_a  <= sd_in;
        r_b   <= r_full[RW-1:0];
        acc_b <= acc_a;
        sd_b  <= sd_a;
      end
    end

    assign acc_o[s]  = acc_b;
    assign rem_o[s]  = r_b;
    assign side_o[s] = sd_b;
    assign vld_o[s]  = v_b;
  end

  assign out_valid = vld_o[NST-1];
  assign quotient  = acc_o[NST-1][W-1:0];
  assign remainder = rem_o[NST-1];
  assign side_out  = side_o[NST-1];

endmodule

// ===== rtl/ecu_tod.sv =====
module ecu_tod #(
  parameter int SIDE_W = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [16:0]              sec_of_day,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output ecu_pkg::hms_t            hms,
  output logic [SIDE_W-1:0]        side_out
);

  localparam logic [17:0] M_3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] M_60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  logic              v1, v2, v3, v4;
  logic [16:0]       t1_rest;
  logic [4:0]        t1_hour, t2_hour, t3_hour, t4_hour;
  logic [11:0]       t2_rem, t3_rem;
  logic [5:0]        t3_min, t4_min, t4_sec;
  logic [SIDE_W-1:0] t1_sd, t2_sd, t3_sd, t4_sd;

  logic [34:0] p_hour;
  logic [24:0] p_min;
  logic [16:0] hour_secs;
  logic [11:0] min_secs;

  assign p_hour    = {18'b0, sec_of_day} * {17'b0, M_3600};
  assign hour_secs = 17'({12'b0, t1_hour} * 17'd3600);
  assign p_min     = {13'b0, t2_rem} * {12'b0, M_60};
  assign min_secs  = 12'({6'b0, t3_min} * 12'd60);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_rest <= sec_of_day;
      t1_hour <= p_hour[33:29];
      t1_sd   <= side_in;

      t2_hour <= t1_hour;
      t2_rem  <= 12'(t1_rest - hour_secs);
      t2_sd   <= t1_sd;

      t3_hour <= t2_hour;
      t3_rem  <= t2_rem;
      t3_min  <= p_min[23:18];
      t3_sd   <= t2_sd;

      t4_hour <= t3_hour;
      t4_min  <= t3_min;
      t4_sec  <= 6'(t3_rem - min_secs);
      t4_sd   <= t3_sd;
    end
  end

  assign out_valid  = v4;
  assign hms.hour   = t4_hour;
  assign hms.minute = t4_min;
  assign hms.second = t4_sec;
  assign side_out   = t4_sd;

endmodule

// ===== rtl/ecu_date.sv =====
module ecu_date (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [17:0]         doe,
  input  logic signed [31:0]  era,
  input  ecu_pkg::hms_t       hms_in,
  output logic                out_valid,
  output ecu_pkg::hms_t       hms_out,
  output logic [4:0]          day_of_month,
  output logic [3:0]          month_index,
  output logic signed [39:0]  year_since_1900,
  output logic [2:0]          weekday,
  output logic [8:0]          year_day
);

  localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] M_7     = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
  localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  M_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] M_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] M_5     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;

  // stage 1
  logic [17:0]        d1_doe;
  logic [6:0]         d1_a1;
  logic [2:0]         d1_a2;
  logic               d1_a3;
  logic [14:0]        d1_q7;
  logic signed [39:0] d1_e400;
  ecu_pkg::hms_t      d1_hms;
  // stage 2
  logic [17:0]        d2_doe, d2_t;
  logic [2:0]         d2_wd;
  logic signed [39:0] d2_e400;
  ecu_pkg::hms_t      d2_hms;
  // stage 3
  logic [17:0]        d3_doe;
  logic [8:0]         d3_yoe;
  logic [2:0]         d3_wd;
  logic signed [39:0] d3_e400;
  ecu_pkg::hms_t      d3_hms;
  // stage 4
  logic [17:0]        d4_doe, d4_y365;
  logic [8:0]         d4_yoe;
  logic [1:0]         d4_yq100;
  logic [2:0]         d4_wd;
  logic signed [39:0] d4_e400;
  ecu_pkg::hms_t      d4_hms;
  // stage 5 onward
  logic [8:0]         d5_doy, d6_doy, d7_doy, d8_doy;
  logic [8:0]         d5_yoe, d6_yoe, d7_yoe, d8_yoe;
  logic               d5_leap, d6_leap, d7_leap, d8_leap;
  logic [2:0]         d5_wd, d6_wd, d7_wd, d8_wd, d9_wd;
  logic signed [39:0] d5_e400, d6_e400, d7_e400, d8_e400;
  ecu_pkg::hms_t      d5_hms, d6_hms, d7_hms, d8_hms, d9_hms;
  logic [10:0]        d6_n, d8_n2;
  logic [3:0]         d7_mp, d8_mp;
  logic [4:0]         d9_mday;
  logic [3:0]         d9_mon;
  logic signed [39:0] d9_year;
  logic [8:0]         d9_yday;

  logic [36:0] p_a1, p_a2, p_q7, p_yoe;
  logic [17:0] doe3;
  logic [17:0] wd_full;
  logic [18:0] p_y100;
  logic [17:0] doy_full;
  logic [8:0]  y100;
  logic [22:0] p_mp, p_q5;
  logic [8:0]  q5;

  assign doe3    = doe + 18'd3;
  assign p_a1    = {18'b0, doe}  * {18'b0, M_1460};
  assign p_a2    = {18'b0, doe}  * {18'b0, M_36524};
  assign p_q7    = {18'b0, doe3} * {18'b0, M_7};
  assign wd_full = (d1_doe + 18'd3) - 18'({3'b0, d1_q7} * 18'd7);
  assign p_yoe   = {18'b0, d2_t} * {18'b0, M_365};
  assign p_y100  = {10'b0, d3_yoe} * {9'b0, M_100};
  assign doy_full = d4_doe - (d4_y365 + {11'b0, d4_yoe[8:2]} - {16'b0, d4_yq100});
  assign y100    = 9'({7'b0, d4_yq100} * 9'd100);
  assign p_mp    = {12'b0, d6_n} * {11'b0, M_153};
  assign p_q5    = {12'b0, d8_n2} * {11'b0, M_5};
  assign q5      = p_q5[22:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= {in_valid, v1, v2, v3, v4, v5, v6, v7, v8};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // era fractions and weekday quotient
      d1_doe  <= doe;
      d1_a1   <= p_a1[35:29];
      d1_a2   <= p_a2[36:34];
      d1_a3   <= (doe == 18'(ecu_pkg::DAYS_PER_ERA - 1));
      d1_q7   <= p_q7[35:21];
      d1_e400 <= 40'(era) * 40'sd400;
      d1_hms  <= hms_in;

      d2_doe  <= d1_doe;
      d2_t    <= d1_doe - {11'b0, d1_a1} + {15'b0, d1_a2} - {17'b0, d1_a3};
      d2_wd   <= wd_full[2:0];
      d2_e400 <= d1_e400;
      d2_hms  <= d1_hms;

      // year of era
      d3_doe  <= d2_doe;
      d3_yoe  <= p_yoe[35:27];
      d3_wd   <= d2_wd;
      d3_e400 <= d2_e400;
      d3_hms  <= d2_hms;

      d4_doe   <= d3_doe;
      d4_yoe   <= d3_yoe;
      d4_yq100 <= p_y100[17:16];
      d4_y365  <= 18'({9'b0, d3_yoe} * 18'd365);
      d4_wd    <= d3_wd;
      d4_e400  <= d3_e400;
      d4_hms   <= d3_hms;

      // day of the march-based year, leap flag of the calendar year it starts in
      d5_doy  <= doy_full[8:0];
      d5_yoe  <= d4_yoe;
      d5_leap <= (d4_yoe[1:0] == 2'd0) && ((d4_yoe != y100) || (d4_yoe == 9'd0));
      d5_wd   <= d4_wd;
      d5_e400 <= d4_e400;
      d5_hms  <= d4_hms;

      d6_doy  <= d5_doy;
      d6_n    <= {d5_doy, 2'b00} + {2'b0, d5_doy} + 11'd2;
      d6_yoe  <= d5_yoe;
      d6_leap <= d5_leap;
      d6_wd   <= d5_wd;
      d6_e400 <= d5_e400;
      d6_hms  <= d5_hms;

      // month counted from march
      d7_doy  <= d6_doy;
      d7_mp   <= p_mp[22:19];
      d7_yoe  <= d6_yoe;
      d7_leap <= d6_leap;
      d7_wd   <= d6_wd;
      d7_e400 <= d6_e400;
      d7_hms  <= d6_hms;

      d8_doy  <= d7_doy;
      d8_mp   <= d7_mp;
      d8_n2   <= 11'({7'b0, d7_mp} * 11'd153) + 11'd2;
      d8_yoe  <= d7_yoe;
      d8_leap <= d7_leap;
      d8_wd   <= d7_wd;
      d8_e400 <= d7_e400;
      d8_hms  <= d7_hms;

      // final calendar fields
      d9_mday <= 5'(d8_doy - q5 + 9'd1);
      if (d8_mp < 4'd10) begin
        d9_mon  <= d8_mp + 4'd2;
        d9_yday <= d8_doy + 9'd59 + {8'b0, d8_leap};
        d9_year <= 40'({31'b0, d8_yoe}) + d8_e400 - 40'sd1900;
      end else begin
        d9_mon  <= d8_mp - 4'd10;
        d9_yday <= d8_doy - 9'd306;
        d9_year <= 40'({31'b0, d8_yoe}) + d8_e400 - 40'sd1899;
      end
      d9_wd  <= d8_wd;
      d9_hms <= d8_hms;
    end
  end

  assign out_valid       = v9;
  assign hms_out         = d9_hms;
  assign day_of_month    = d9_mday;
  assign month_index     = d9_mon;
  assign year_since_1900 = d9_year;
  assign weekday         = d9_wd;
  assign year_day        = d9_yday;

endmodule

// ===== rtl/epoch_seconds_to_civil_utc.sv =====
// structure: seconds divider, first correction register, time-of-day split, era divider,
// second correction register and date stages; each chunk of the two constant dividers
// registers its quotient digit first and then its remainder
// throughput: one timestamp per cycle, the whole pipeline advances while the output
// register is empty or its result is taken in the same cycle
// reset: synchronous, clears all valid bits; payload registers keep their contents
module epoch_seconds_to_civil_utc #(
  parameter int STEPS_PER_STAGE = ecu_pkg::DIV_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] epoch_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         second_of_minute,
  output logic [5:0]         minute_of_hour,
  output logic [4:0]         hour_of_day,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month_index,
  output logic signed [39:0] year_since_1900,
  output logic [2:0]         weekday,
  output logic [8:0]         year_day
);

  // signed floor division is done as unsigned division of a biased value:
  // x + 2^(n-1) = q*D + r, then floor(x/D) = q - K - (r < R), with 2^(n-1) = K*D + R
  localparam logic [64:0] SEC_BIAS = 65'd1 << 63;
  localparam logic [64:0] SEC_K    = SEC_BIAS / 65'(ecu_pkg::SECS_PER_DAY);
  localparam logic [16:0] SEC_R    = 17'(SEC_BIAS % 65'(ecu_pkg::SECS_PER_DAY));
  // epoch shift folded into the day correction
  localparam logic [64:0] DAY_K    = SEC_K - 65'(ecu_pkg::EPOCH_SHIFT);

  localparam logic [48:0] DAY_BIAS = 49'd1 << 47;
  localparam logic [48:0] ERA_K    = DAY_BIAS / 49'(ecu_pkg::DAYS_PER_ERA);
  localparam logic [17:0] ERA_R    = 18'(DAY_BIAS % 49'(ecu_pkg::DAYS_PER_ERA));

  logic en;

  // seconds divider
  logic        sd_valid;
  logic [63:0] sd_q;
  logic [16:0] sd_r;

  // first correction stage: shifted day number and second of the day
  logic        f1_valid;
  logic [47:0] f1_x;
  logic [16:0] f1_rest;
  logic        f1_borrow;

  // time of day split
  logic          td_valid;
  ecu_pkg::hms_t td_hms;
  logic [47:0]   td_x;

  // era divider
  logic          ed_valid;
  logic [47:0]   ed_q;
  logic [17:0]   ed_r;
  ecu_pkg::hms_t ed_hms;

  // second correction stage: era and day of era
  logic               f2_valid;
  logic signed [31:0] f2_era;
  logic [17:0]        f2_doe;
  ecu_pkg::hms_t      f2_hms;
  logic               f2_borrow;

  ecu_pkg::hms_t out_hms;

  // the whole pipeline moves together; it holds only when a finished result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ecu_cdiv #(
    .W       (ecu_pkg::SEC_W),
    .DIVISOR (ecu_pkg::SECS_PER_DAY),
    .SPS     (STEPS_PER_STAGE),
    .SIDE_W  (1)
  ) u_sec_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  ({~epoch_seconds[63], epoch_seconds[62:0]}),
    .side_in   (1'b0),
    .out_valid (sd_valid),
    .quotient  (sd_q),
    .remainder (sd_r),
    .side_out  ()
  );

  assign f1_borrow = (sd_r < SEC_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= sd_valid;
    end
  end

  // day + epoch shift fits 48 bits signed for every input
  always_ff @(posedge clk) begin
    if (en) begin
      f1_x <= sd_q[47:0] - DAY_K[47:0] - {47'b0, f1_borrow};
      if (f1_borrow) begin
        f1_rest <= 17'(sd_r + (17'(ecu_pkg::SECS_PER_DAY) - SEC_R));
      end else begin
        f1_rest <= sd_r - SEC_R;
      end
    end
  end

  ecu_tod #(
    .SIDE_W (ecu_pkg::DAY_W)
  ) u_tod (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (f1_valid),
    .sec_of_day (f1_rest),
    .side_in    (f1_x),
    .out_valid  (td_valid),
    .hms        (td_hms),
    .side_out   (td_x)
  );

  ecu_cdiv #(
    .W       (ecu_pkg::DAY_W),
    .DIVISOR (ecu_pkg::DAYS_PER_ERA),
    .SPS     (STEPS_PER_STAGE),
    .SIDE_W  (ecu_pkg::TOD_W)
  ) u_era_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (td_valid),
    .dividend  ({~td_x[47], td_x[46:0]}),
    .side_in   (td_hms),
    .out_valid (ed_valid),
    .quotient  (ed_q),
    .remainder (ed_r),
    .side_out  (ed_hms)
  );

  assign f2_borrow = (ed_r < ERA_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= ed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_era <= ed_q[31:0] - ERA_K[31:0] - {31'b0, f2_borrow};
      if (f2_borrow) begin
        f2_doe <= 18'(ed_r + (18'(ecu_pkg::DAYS_PER_ERA) - ERA_R));
      end else begin
        f2_doe <= ed_r - ERA_R;
      end
      f2_hms <= ed_hms;
    end
  end

  // calendar fields from era and day of era; last stage is the output register
  ecu_date u_date (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (f2_valid),
    .doe             (f2_doe),
    .era             (f2_era),
    .hms_in          (f2_hms),
    .out_valid       (out_valid),
    .hms_out         (out_hms),
    .day_of_month    (day_of_month),
    .month_index     (month_index),
    .year_since_1900 (year_since_1900),
    .weekday         (weekday),
    .year_day        (year_day)
  );

  assign hour_of_day      = out_hms.hour;
  assign minute_of_hour   = out_hms.minute;
  assign second_of_minute = out_hms.second;

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected civil breakdown per accepted timestamp
  typedef struct {
    logic [5:0]         sec;
    logic [5:0]         min;
    logic [4:0]         hour;
    logic [4:0]         mday;
    logic [3:0]         mon;
    logic signed [39:0] year;
    logic [2:0]         wday;
    logic [8:0]         yday;
  } civil_t;

  localparam int PIPE_LATENCY = 60;  // longer than a timestamp takes through the rtl pipeline at default stage size
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [63:0] epoch_seconds = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         second_of_minute;
  logic [5:0]         minute_of_hour;
  logic [4:0]         hour_of_day;
  logic [4:0]         day_of_month;
  logic [3:0]         month_index;
  logic signed [39:0] year_since_1900;
  logic [2:0]         weekday;
  logic [8:0]         year_day;

  epoch_seconds_to_civil_utc i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .epoch_seconds    (epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_month     (day_of_month),
    .month_index      (month_index),
    .year_since_1900  (year_since_1900),
    .weekday          (weekday),
    .year_day         (year_day)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor division by a positive divisor, remainder always in 0..d-1
  function automatic longint floor_quot(input longint a, input longint d, output longint r);
    longint q;
    q = a / d;
    r = a % d;
    if (r < 0) begin
      r = r + d;
      q = q - 1;
    end
    return q;
  endfunction

  // day number of january 1 of a civil year, relative to the epoch
  function automatic longint jan1_day(input longint yr);
    longint y, yoe, era;
    y   = yr - 1;
    era = floor_quot(y, 400, yoe);
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + 306 - 719468;
  endfunction

  // timestamp to civil date, march-based 400-year eras
  function automatic civil_t civil_from_epoch(input longint secs);
    civil_t c;
    longint tod, days, doe, era, yoe, doy, mp, mday, mon, yr, wrem;
    days = floor_quot(secs, 86400, tod);
    era  = floor_quot(days + 719468, 146097, doe);
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mday = doy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    void'(floor_quot(days, 7, wrem));
    c.sec  = 6'(tod % 60);
    c.min  = 6'((tod / 60) % 60);
    c.hour = 5'(tod / 3600);
    c.mday = 5'(mday);
    c.mon  = 4'(mon - 1);
    c.year = 40'(yr - 1900);
    c.wday = 3'((wrem + 4) % 7);
    c.yday = 9'(days - jan1_day(yr));
    return c;
  endfunction

  longint pending_secs[$];
  civil_t expected_dates[$];
  int     send_gap_pct = 9;
  int     recv_gap_pct = 55;
  int     hold_recv    = 0;  // cycles the receiver still holds off
  bit     send_pause   = 1'b0;
  int     errors       = 0;
  int     checked      = 0;
  int     idle_cycles  = 0;

  // driver: valid stays up with a fixed payload until the transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(civil_from_epoch(epoch_seconds));
      end
      if (!in_valid || in_ready) begin
        if (pending_secs.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_gap_pct) begin
          in_valid      <= 1'b1;
          epoch_seconds <= pending_secs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    civil_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual year %0d", $time,
                   year_since_1900);
          errors++;
        end else begin
          e = expected_dates.pop_front();
          checked++;
          if ({second_of_minute, minute_of_hour, hour_of_day, day_of_month, month_index,
               year_since_1900, weekday, year_day} !==
              {e.sec, e.min, e.hour, e.mday, e.mon, e.year, e.wday, e.yday}) begin
            $display("%0t: mismatch expected s=%0d m=%0d h=%0d d=%0d mo=%0d y=%0d wd=%0d yd=%0d",
                     $time, e.sec, e.min, e.hour, e.mday, e.mon, e.year, e.wday, e.yday);
            $display("%0t:          actual s=%0d m=%0d h=%0d d=%0d mo=%0d y=%0d wd=%0d yd=%0d",
                     $time, second_of_minute, minute_of_hour, hour_of_day, day_of_month,
                     month_index, year_since_1900, weekday, year_day);
            errors++;
          end
        end
      end
      if (hold_recv > 0) begin
        hold_recv <= hold_recv - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // random timestamp: half near the present, the rest wide, full-range or next to day boundaries
  function automatic longint rand_secs();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) begin
      return longint'($urandom_range(32'hFFFF_FFFF)) - 64'sd2147483648 + 64'sd1000000000;
    end else if (sel < 7) begin
      return longint'({$urandom(), $urandom()}) >>> $urandom_range(63);
    end else if (sel < 8) begin
      // around day boundaries
      return longint'(int'($urandom_range(400000)) - 200000) * 86400 +
             longint'($urandom_range(4)) - 2;
    end else begin
      return {$urandom(), $urandom()};
    end
  endfunction

  task automatic wait_drained();
    while (pending_secs.size() > 0 || in_valid || expected_dates.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    longint edge_vals[$];
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes, epoch, sign change, leap days and century rules
    edge_vals = '{64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF, 0, -1, 1,
                  86399, 86400, -86400, -86401, 951782400, 951868800, 64'sd4107456000,
                  -64'sd2203891200, 68169600, 1709164800, 1735689599, 1735603200,
                  -64'sd62167219200, -64'sd62135596800, 64'sd253402300799,
                  64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA};
    foreach (edge_vals[k]) pending_secs.push_back(edge_vals[k]);
    wait_drained();

    // phase 1: sender mostly busy, receiver slow, with one long receiver hold-off
    for (n = 0; n < 580; n++) pending_secs.push_back(rand_secs());
    hold_recv = 200;
    wait_drained();

    // sender pause: every result has arrived before restarting
    send_pause = 1'b1;
    repeat (PIPE_LATENCY) @(posedge clk);
    send_pause = 1'b0;

    // phase 2: roles swapped
    send_gap_pct = 55;
    recv_gap_pct = 9;
    for (n = 0; n < 580; n++) pending_secs.push_back(rand_secs());
    wait_drained();

    // phase 3: full rate both ways
    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (n = 0; n < 580; n++) pending_secs.push_back(rand_secs());
    wait_drained();
    repeat (PIPE_LATENCY) @(posedge clk);

    $display("covered %0d timestamps: full 64-bit extremes, day/leap/century edges,", checked);
    $display("random values under slow, bursty and full-rate flow with a long output stall");
    if (errors == 0 && expected_dates.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ecu_pkg.sv
rtl/ecu_cdiv.sv
rtl/ecu_tod.sv
rtl/ecu_date.sv
rtl/epoch_seconds_to_civil_utc.sv
tb/tb.sv
